// ----- design/tgl_pkg.sv -----
// tgl_pkg: shared types, codes and color helpers for the text glyph layout unit
// no dependencies; imported by text_glyph_layout_unit
`timescale 1ns / 1ps

package tgl_pkg;

    // configuration register indexes
    typedef enum logic [7:0] {
        CFG_ORIGIN_X   = 8'd0,
        CFG_ORIGIN_Y   = 8'd1,
        CFG_BASE_COLOR = 8'd2,
        CFG_DARKEN     = 8'd3
    } t_cfg_index;

    // input item kinds carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEXT = 1'b1;

    localparam logic [7:0]  AMP_CHAR    = 8'h26;
    localparam logic [23:0] DARKEN_MASK = 24'hFCFCFC;
    localparam logic [7:0]  CODE_LEVEL  = 8'd191;
    localparam logic [7:0]  CODE_BOOST  = 8'h80;
    localparam logic [23:0] RESET_COLOR = 24'hFFFFFF;

    // hex digit decode result
    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } t_hex;

    // darken mode drops the two low bits of each channel and divides by four
    function automatic logic [23:0] shade(input logic [23:0] col, input logic dark);
        shade = dark ? ((col & DARKEN_MASK) >> 2) : col;
    endfunction

    // one channel of a color code, clamped to 255
    function automatic logic [7:0] code_channel(input logic on, input logic boost);
        logic [8:0] sum;
        sum = (on ? {1'b0, CODE_LEVEL} : 9'd0) + (boost ? {1'b0, CODE_BOOST} : 9'd0);
        code_channel = sum[8] ? 8'hFF : sum[7:0];
    endfunction

    // color code digit to RGB: bit 0 blue, bit 1 green, bit 2 red, bit 3 boost
    function automatic logic [23:0] code_color(input logic [3:0] code);
        code_color = {code_channel(code[2], code[3]),
                      code_channel(code[1], code[3]),
                      code_channel(code[0], code[3])};
    endfunction

    // lowercase hex digit decode
    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.hit   = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.hit   = 1'b1;
            h.value = c[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.hit   = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        hex_digit = h;
    endfunction

endpackage

// ----- design/text_glyph_layout_unit.sv -----
// text_glyph_layout_unit: turns text bytes into glyph placements on a 16x16 font grid
// depends on tgl_pkg (codes, color helpers)
`timescale 1ns / 1ps

// Usage
// - slave stream: tuser = 0 loads a width table entry, tuser = 1 is a text byte;
//   tlast marks the final byte of a string. Load transactions produce nothing.
// - master stream: one transaction per placed glyph, or an end-only marker when a
//   string ends on a color code; tuser set = glyph placed, tlast = end of string.
// - config channel: index 0 origin x, 1 origin y, 2 base color, 3 darken; write
//   only while the unit is idle.
// - a text byte's width is read from the table and its item loaded into the layout
//   stage when its transaction is accepted; the layout stage then loads the output
//   register, which drives the master output.
// - throughput: one byte per cycle while the master side takes results, set by the
//   single-ported width table read and the one-step update of advance and color;
//   an '&' followed by a non-digit holds the layout stage since it places two glyphs.
// - reset clears the width table (per-entry valid flags), advance, pending '&' and
//   loads the register defaults; no clearing pass is needed.
// - a stalled master side holds the output register; the layout stage and then the
//   slave side back up behind it, nothing is dropped.
module text_glyph_layout_unit #(
    parameter int CHAR_CODES      = 256,
    parameter int MAX_GLYPH_WIDTH = 8,
    parameter int ADVANCE_BITS    = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[7:0], width_value[11:8], zero[15:12]
    input  logic        s_tuser,   // action
    input  logic        s_tlast,   // last_char
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // screen_x[16:0], screen_y[32:17], cell_column[36:33],
                                   // cell_row[40:37], glyph_color[64:41], text_width[79:65]
    output logic        m_tuser,   // glyph_valid
    output logic        m_tlast,   // end_of_text
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import tgl_pkg::*;

    localparam int CODE_BITS = $clog2(CHAR_CODES);
    localparam logic [8:0] CODE_LIMIT = 9'(CHAR_CODES);
    localparam logic [3:0] WIDTH_MAX = 4'(MAX_GLYPH_WIDTH);
    localparam logic [ADVANCE_BITS-1:0] ADV_MAX = {ADVANCE_BITS{1'b1}};

    // configuration registers
    logic signed [15:0] r_origin_x;
    logic signed [15:0] r_origin_y;
    logic [23:0]        r_base_color;
    logic               r_darken;

    // width table memory with per-entry valid flags
    logic [3:0]            r_wtab [CHAR_CODES];
    logic [CHAR_CODES-1:0] r_wval;
    logic [3:0]            r_amp_width;
    logic [3:0]            r_rd_data;
    logic                  r_rd_valid;

    // layout stage item
    logic       r_a_valid;
    logic [7:0] r_a_char;
    logic       r_a_last;

    // string state
    logic [ADVANCE_BITS-1:0] r_adv;
    logic [23:0]             r_color;
    logic                    r_pending;
    logic                    r_phase;

    // output register
    logic        r_o_valid;
    logic [79:0] r_o_data;
    logic        r_o_user;
    logic        r_o_last;

    // input decode
    logic [7:0]           in_char;
    logic [3:0]           in_wv;
    logic [CODE_BITS-1:0] in_idx;
    logic                 in_range;
    logic                 in_accept;
    logic [3:0]           in_wclamp;

    assign in_char   = s_tdata[7:0];
    assign in_wv     = s_tdata[11:8];
    assign in_idx    = in_char[CODE_BITS-1:0];
    assign in_range  = {1'b0, in_char} < CODE_LIMIT;
    assign in_accept = s_tvalid && s_tready;
    assign in_wclamp = (in_wv > WIDTH_MAX) ? WIDTH_MAX : in_wv;

    // layout stage combinational step
    t_hex                    hx;
    logic                    step_emit;
    logic                    step_done;
    logic                    a_fire;
    logic                    out_free;
    logic                    n_pending;
    logic                    n_phase;
    logic                    n_finish;
    logic [ADVANCE_BITS-1:0] n_adv;
    logic [23:0]             n_color;
    logic                    e_glyph;
    logic                    e_end;
    logic [7:0]              e_char;
    logic [3:0]              e_width;
    logic [ADVANCE_BITS:0]   adv_sum;
    logic [ADVANCE_BITS-1:0] adv_sat;
    logic signed [17:0]      sx_sum;
    logic [16:0]             e_sx;
    logic [16:0]             tw_ext;
    logic [14:0]             e_tw;
    logic [79:0]             e_data;

    assign hx       = hex_digit(r_a_char);
    assign out_free = !r_o_valid || m_tready;

    always_comb begin
        step_emit = 1'b0;
        step_done = 1'b1;
        n_pending = r_pending;
        n_phase   = 1'b0;
        n_finish  = 1'b0;
        n_color   = r_color;
        e_glyph   = 1'b0;
        e_end     = 1'b0;
        e_char    = r_a_char;
        e_width   = r_rd_valid ? r_rd_data : 4'd0;
        if (r_pending && !r_phase) begin
            n_pending = 1'b0;
            if (hx.hit) begin
                // color code: new color, an end-only marker if the string ends here
                n_color = shade(code_color(hx.value), r_darken);
                if (r_a_last) begin
                    step_emit = 1'b1;
                    e_end     = 1'b1;
                    n_finish  = 1'b1;
                end
            end else begin
                // held '&' goes out first, the byte itself after it
                step_emit = 1'b1;
                step_done = 1'b0;
                e_glyph   = 1'b1;
                e_char    = AMP_CHAR;
                e_width   = r_amp_width;
                n_phase   = 1'b1;
            end
        end else if (r_a_char == AMP_CHAR && !r_a_last) begin
            n_pending = 1'b1;
        end else begin
            step_emit = 1'b1;
            e_glyph   = 1'b1;
            e_end     = r_a_last;
            n_finish  = r_a_last;
        end
    end

    assign a_fire = r_a_valid && (!step_emit || out_free);

    // advance update and screen x
    assign adv_sum = {1'b0, r_adv} + {{(ADVANCE_BITS-3){1'b0}}, e_width};
    assign adv_sat = adv_sum[ADVANCE_BITS] ? ADV_MAX : adv_sum[ADVANCE_BITS-1:0];
    assign n_adv   = e_glyph ? adv_sat : r_adv;
    assign sx_sum  = {{2{r_origin_x[15]}}, r_origin_x} + {{(18-ADVANCE_BITS){1'b0}}, r_adv};
    assign e_sx    = (sx_sum > 18'sd65535) ? 17'h0FFFF : sx_sum[16:0];
    assign tw_ext  = {{(17-ADVANCE_BITS){1'b0}}, n_adv};
    assign e_tw    = (tw_ext > 17'd32767) ? 15'h7FFF : tw_ext[14:0];

    // result fields; in an end-only marker all but text_width are zero
    always_comb begin
        e_data = '0;
        e_data[79:65] = e_tw;
        if (e_glyph) begin
            e_data[16:0]  = e_sx;
            e_data[32:17] = r_origin_y;
            e_data[36:33] = e_char[3:0];
            e_data[40:37] = e_char[7:4];
            e_data[64:41] = r_color;
        end
    end

    assign s_tready    = !r_a_valid || (a_fire && step_done);
    assign o_cfg_ready = 1'b1;

    // width table memory write and registered read
    always_ff @(posedge i_clk) begin
        if (in_accept && s_tuser == ACT_LOAD && in_range) begin
            r_wtab[in_idx] <= in_wclamp;
        end
        if (in_accept && s_tuser == ACT_TEXT) begin
            r_rd_data <= r_wtab[in_idx];
        end
    end

    // valid flags, shadow width of '&', and the valid part of the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wval      <= '0;
            r_amp_width <= 4'd0;
            r_rd_valid  <= 1'b0;
        end else if (in_accept) begin
            if (s_tuser == ACT_LOAD) begin
                if (in_range) begin
                    r_wval[in_idx] <= 1'b1;
                end
                if (in_char == AMP_CHAR) begin
                    r_amp_width <= in_wclamp;
                end
            end else begin
                r_rd_valid <= in_range && r_wval[in_idx];
            end
        end
    end

    // layout stage item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_tready) begin
            r_a_valid <= in_accept && s_tuser == ACT_TEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && s_tuser == ACT_TEXT) begin
            r_a_char <= in_char;
            r_a_last <= s_tlast;
        end
    end

    // configuration registers and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_base_color <= RESET_COLOR;
            r_darken     <= 1'b0;
            r_adv        <= '0;
            r_color      <= RESET_COLOR;
            r_pending    <= 1'b0;
            r_phase      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: begin
                    r_origin_x <= i_cfg_data[15:0];
                end
                CFG_ORIGIN_Y: begin
                    r_origin_y <= i_cfg_data[15:0];
                end
                CFG_BASE_COLOR: begin
                    r_base_color <= i_cfg_data;
                    r_color      <= shade(i_cfg_data, r_darken);
                end
                CFG_DARKEN: begin
                    r_darken <= i_cfg_data[0];
                    r_color  <= shade(r_base_color, i_cfg_data[0]);
                end
                default: begin
                end
            endcase
        end else if (a_fire) begin
            r_phase <= n_phase;
            if (n_finish) begin
                r_adv     <= '0;
                r_pending <= 1'b0;
                r_color   <= shade(r_base_color, r_darken);
            end else begin
                r_adv     <= n_adv;
                r_pending <= n_pending;
                r_color   <= n_color;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_fire && step_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && step_emit) begin
            r_o_data <= e_data;
            r_o_user <= e_glyph;
            r_o_last <= e_end;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = r_o_data;
    assign m_tuser  = r_o_user;
    assign m_tlast  = r_o_last;

endmodule

// ----- bench/text_glyph_layout_unit_tb.sv -----
// text_glyph_layout_unit_tb: self-checking bench for the text glyph layout unit
// drives width loads and text strings, predicts glyph placements, checks every result
// depends on tgl_pkg and text_glyph_layout_unit
`timescale 1ns / 1ps

module text_glyph_layout_unit_tb;
    import tgl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WIDTH   = 8;
    localparam int ADV_LIMIT   = 32767;
    localparam int SETTLE      = 6;

    // one slave transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] code;
        logic [3:0] wval;
        logic       last;
    } t_stim_item;

    // one master transaction
    typedef struct packed {
        logic        glyph;
        logic [16:0] sx;
        logic [15:0] sy;
        logic [3:0]  col;
        logic [3:0]  row;
        logic [23:0] color;
        logic        eot;
        logic [14:0] width;
    } t_glyph_res;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic        s_tuser     = 1'b0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data  = '0;

    text_glyph_layout_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // layout state mirror
    logic signed [15:0] org_x    = '0;
    logic signed [15:0] org_y    = '0;
    logic [23:0]        base_col = RESET_COLOR;
    logic               dark     = 1'b0;
    logic [3:0]         width_tab [256];
    logic [14:0]        adv      = '0;
    logic [23:0]        cur_color = RESET_COLOR;
    logic               pend_amp = 1'b0;

    t_stim_item item_q [$];
    t_glyph_res glyph_expect_q [$];
    t_stim_item nxt_item;

    int  cycle_cnt      = 0;
    int  err_cnt        = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  s_fire         = 1'b0;

    // bytes just outside the hex digit ranges, plus uppercase 'F' and zero
    logic [7:0] near_hex [6] = '{8'h2F, 8'h3A, 8'h60, 8'h67, 8'h46, 8'h00};

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic note_error(input string msg);
        err_cnt++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic cmp_field(input string fname, input longint got, input longint want);
        if (got != want)
            note_error($sformatf("%s got %0h want %0h", fname, got, want));
    endtask

    // darken mode dims every channel to a quarter; otherwise the color passes unchanged
    function automatic logic [23:0] dim(input logic [23:0] col);
        return dark ? ((col & DARKEN_MASK) >> 2) : col;
    endfunction

    function automatic logic [23:0] digit_color(input logic [3:0] code);
        logic [23:0] col;
        int          lvl;
        for (int ch = 0; ch < 3; ch++) begin
            lvl = (code[ch] ? int'(CODE_LEVEL) : 0) + (code[3] ? int'(CODE_BOOST) : 0);
            if (lvl > 255)
                lvl = 255;
            col[ch*8 +: 8] = lvl[7:0];
        end
        return col;
    endfunction

    function automatic int hex_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    // place one glyph and advance, saturating
    task automatic lay_glyph(input logic [7:0] c, input logic eot);
        t_glyph_res r;
        int         sx;
        int         nadv;
        sx = int'(org_x) + int'(adv);
        if (sx > 65535)
            sx = 65535;
        nadv = int'(adv) + int'(width_tab[c]);
        if (nadv > ADV_LIMIT)
            nadv = ADV_LIMIT;
        adv     = nadv[14:0];
        r.glyph = 1'b1;
        r.sx    = sx[16:0];
        r.sy    = org_y;
        r.col   = c[3:0];
        r.row   = c[7:4];
        r.color = cur_color;
        r.eot   = eot;
        r.width = adv;
        glyph_expect_q.push_back(r);
    endtask

    task automatic end_string();
        adv       = '0;
        pend_amp  = 1'b0;
        cur_color = dim(base_col);
    endtask

    // text byte: color codes, held ampersand, glyph placement
    task automatic layout_text(input logic [7:0] c, input logic last);
        t_glyph_res mark;
        int         code;
        if (pend_amp) begin
            pend_amp = 1'b0;
            code = hex_of(c);
            if (code >= 0) begin
                cur_color = dim(digit_color(code[3:0]));
                if (last) begin
                    mark       = '0;
                    mark.eot   = 1'b1;
                    mark.width = adv;
                    glyph_expect_q.push_back(mark);
                    end_string();
                end
                return;
            end
            lay_glyph(AMP_CHAR, 1'b0);
        end
        if (c == AMP_CHAR && !last) begin
            pend_amp = 1'b1;
            return;
        end
        lay_glyph(c, last);
        if (last)
            end_string();
    endtask

    task automatic apply_reg(input logic [7:0] idx, input logic [23:0] val);
        case (idx)
            CFG_ORIGIN_X: org_x = val[15:0];
            CFG_ORIGIN_Y: org_y = val[15:0];
            CFG_BASE_COLOR: begin
                base_col  = val;
                cur_color = dim(base_col);
            end
            CFG_DARKEN: begin
                dark      = val[0];
                cur_color = dim(base_col);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_glyph_res want;
        if (glyph_expect_q.size() == 0) begin
            note_error("result with no expectation pending");
            return;
        end
        want = glyph_expect_q.pop_front();
        cmp_field("glyph_valid", m_tuser, want.glyph);
        cmp_field("screen_x", m_tdata[16:0], want.sx);
        cmp_field("screen_y", m_tdata[32:17], want.sy);
        cmp_field("cell_column", m_tdata[36:33], want.col);
        cmp_field("cell_row", m_tdata[40:37], want.row);
        cmp_field("glyph_color", m_tdata[64:41], want.color);
        cmp_field("end_of_text", m_tlast, want.eot);
        cmp_field("text_width", m_tdata[79:65], want.width);
    endtask

    // monitor: config writes, accepted items, results, cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("text_glyph_layout_unit regression: fail");
            $finish;
        end else begin
            s_fire = i_rst_n && s_tvalid && s_tready;
            if (i_rst_n) begin
                if (m_tvalid && m_tready)
                    check_result();
                if (i_cfg_valid && o_cfg_ready)
                    apply_reg(i_cfg_index, i_cfg_data);
                if (s_fire) begin
                    if (s_tuser == ACT_LOAD)
                        width_tab[s_tdata[7:0]] =
                            (s_tdata[11:8] > MAX_WIDTH) ? 4'(MAX_WIDTH) : s_tdata[11:8];
                    else
                        layout_text(s_tdata[7:0], s_tlast);
                end
            end
        end
    end

    // driver: slave side from the pending queue, master side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_item = item_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt_item.kind;
                s_tdata  <= {4'b0000, nxt_item.wval, nxt_item.code};
                s_tlast  <= nxt_item.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_load(input logic [7:0] idx, input logic [3:0] w, input logic lst);
        item_q.push_back('{kind: ACT_LOAD, code: idx, wval: w, last: lst});
    endtask

    task automatic push_text(input logic [7:0] c, input logic lst);
        item_q.push_back('{kind: ACT_TEXT, code: c, wval: 4'($urandom_range(15)), last: lst});
    endtask

    function automatic logic [7:0] pick_char();
        string hexs;
        int    r;
        hexs = "0123456789abcdef";
        r = $urandom_range(99);
        if (r < 25)
            return AMP_CHAR;
        if (r < 50)
            return hexs[$urandom_range(15)];
        if (r < 60)
            return near_hex[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    // mostly well-formed strings, with loose width loads and stray bytes
    task automatic queue_strings(input int budget);
        int n;
        int len;
        int r;
        n = 0;
        while (n < budget) begin
            r = $urandom_range(99);
            if (r < 8) begin
                push_load(8'($urandom_range(255)), 4'($urandom_range(15)), 1'($urandom_range(1)));
                n++;
            end else if (r < 12) begin
                push_text(8'($urandom_range(255)), 1'($urandom_range(1)));
                n++;
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    push_text(pick_char(), i == len - 1);
                n += len;
            end
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [23:0] base, input logic dk);
        write_reg(CFG_ORIGIN_X, {8'h00, ox});
        write_reg(CFG_ORIGIN_Y, {8'h00, oy});
        write_reg(CFG_DARKEN, {23'd0, dk});
        write_reg(CFG_BASE_COLOR, base);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            3: begin send_idle_pct = 31; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // wait until every queued item is sent and every expected result is back, then let the pipe settle
    task automatic wait_drained();
        while (item_q.size() != 0 || s_tvalid || glyph_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < 256; i++)
            width_tab[i] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: width clamp, table corners, color codes, held ampersand cases
        set_idle(0);
        push_load(8'h41, 4'd15, 1'b0);
        push_load(AMP_CHAR, 4'd5, 1'b0);
        push_load(8'hFF, 4'd8, 1'b1);
        push_load(8'h00, 4'd0, 1'b0);
        push_load(8'h66, 4'd3, 1'b0);
        push_text(8'h41, 1'b0);
        push_text(AMP_CHAR, 1'b0);
        push_text(8'h30, 1'b0);
        push_text(8'h41, 1'b0);
        push_text(AMP_CHAR, 1'b0);
        push_text(8'h66, 1'b0);
        push_text(AMP_CHAR, 1'b0);
        push_text(8'h78, 1'b0);
        push_text(AMP_CHAR, 1'b0);
        push_text(AMP_CHAR, 1'b0);
        push_text(8'h67, 1'b0);
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(AMP_CHAR, 1'b1);
        push_text(AMP_CHAR, 1'b0);
        push_text(8'h37, 1'b1);
        push_text(AMP_CHAR, 1'b0);
        push_text(8'h00, 1'b1);
        wait_drained();

        // random phases across register settings and idle patterns
        for (int ph = 1; ph <= 5; ph++) begin
            set_idle(ph % 4);
            case (ph)
                1: set_regs(16'h8000, 16'h7FFF, 24'h000000, 1'b0);
                2: set_regs(16'h7FFF, 16'h8000, 24'hFFFFFF, 1'b1);
                4: set_regs(16'($urandom), 16'($urandom), 24'($urandom), 1'b1);
                default: set_regs(16'($urandom), 16'($urandom), 24'($urandom), 1'b0);
            endcase
            if (ph == 3) begin
                queue_strings(130);
                wait_drained();
                queue_strings(140);
            end else begin
                queue_strings(270);
            end
            wait_drained();
        end

        if (glyph_expect_q.size() != 0)
            note_error("expected results left over");
        if (err_cnt == 0)
            $display("text_glyph_layout_unit regression: pass");
        else
            $display("text_glyph_layout_unit regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/tgl_pkg.sv
design/text_glyph_layout_unit.sv
bench/text_glyph_layout_unit_tb.sv
